@@ sv/console_line_assembler_assert.svh @@
// assertion macros for the console line assembler
`ifndef CONSOLE_LINE_ASSEMBLER_ASSERT_SVH
`define CONSOLE_LINE_ASSEMBLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked while out of reset
`define CLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define CLA_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLA_ASSERT(lbl, prop, msg)
`define CLA_ASSERT_ALL(lbl, prop, msg)
`endif

`endif

@@ sv/cla_pkg.sv @@
// types and character constants shared by the console line assembler
`default_nettype none
package cla_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LOW_M = 8'h6d;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_OVERFLOW = 2'd1,
    MODE_ESCAPE   = 2'd2
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic fetch;
    logic next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/cla_in_if.sv @@
// character input channel
`default_nettype none
interface cla_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface
`default_nettype wire

@@ sv/cla_out_if.sv @@
// line character output channel
`default_nettype none
interface cla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

@@ sv/cla_dp.sv @@
// datapath: parser state, line store and readout registers
`default_nettype none
`include "console_line_assembler_assert.svh"
module cla_dp #(
  parameter int LINE_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  cla_pkg::cmd_t cmd,
  output cla_pkg::sts_t sts,
  output logic [7:0]    out_char,
  output logic          out_last
);
  import cla_pkg::*;

  localparam int MAX_CHARS = LINE_BYTES - 2;
  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int LW = $clog2(MAX_CHARS + 1);

  logic [7:0]    mem [MAX_CHARS];
  logic          strip_r;
  mode_t         mode_r, mode_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] vis_r, vis_nxt;
  logic          nul_r, nul_nxt;
  logic          ns_r, ns_nxt;
  logic [LW-1:0] emit_len_r;
  logic [AW-1:0] idx_r;
  logic [7:0]    rdata_r;
  logic          last_r;
  logic          esc_body;
  logic          normal;
  logic          close;
  logic          wr_en;

  assign esc_body = (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_SEMI ||
                    ch == CH_LBRK || ch == CH_RBRK || ch == CH_LOW_M;

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    vis_nxt  = vis_r;
    nul_nxt  = nul_r;
    ns_nxt   = ns_r;
    normal   = 1'b0;
    close    = 1'b0;
    wr_en    = 1'b0;
    case (mode_r)
      MODE_ESCAPE: begin
        // the byte that ends a sequence is handled as a normal one
        normal = !esc_body;
      end
      MODE_OVERFLOW: begin
        if (ch == CH_NL) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        normal = 1'b1;
      end
    endcase
    if (normal) begin
      mode_nxt = MODE_NORMAL;
      if (ch == CH_NL) begin
        close = 1'b1;
      end else if (strip_r && ch == CH_ESC) begin
        mode_nxt = MODE_ESCAPE;
      end else if (len_r >= LW'(MAX_CHARS)) begin
        mode_nxt = MODE_OVERFLOW;
        close    = 1'b1;
      end else begin
        wr_en   = 1'b1;
        len_nxt = len_r + LW'(1);
        if (!nul_r) begin
          if (ch == CH_NUL) begin
            nul_nxt = 1'b1;
          end else begin
            vis_nxt = vis_r + LW'(1);
            if (ch != CH_SPACE) begin
              ns_nxt = 1'b1;
            end
          end
        end
      end
      if (close) begin
        len_nxt = '0;
        vis_nxt = '0;
        nul_nxt = 1'b0;
        ns_nxt  = 1'b0;
      end
    end
  end

  assign sts.emit = close && ns_r;
  assign sts.last = last_r;
  assign out_char = rdata_r;
  assign out_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r <= 1'b1;
      mode_r  <= MODE_NORMAL;
      len_r   <= '0;
      vis_r   <= '0;
      nul_r   <= 1'b0;
      ns_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        strip_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        mode_r <= mode_nxt;
        len_r  <= len_nxt;
        vis_r  <= vis_nxt;
        nul_r  <= nul_nxt;
        ns_r   <= ns_nxt;
        idx_r  <= '0;
      end else if (cmd.next) begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  // line store and its registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[len_r[AW-1:0]] <= ch;
    end
    if (cmd.accept) begin
      emit_len_r <= vis_r;
    end
    if (cmd.fetch) begin
      rdata_r <= mem[idx_r];
      last_r  <= (LW'(idx_r) + LW'(1)) == emit_len_r;
    end
  end

  `CLA_ASSERT(a_len_bound, len_r <= LW'(MAX_CHARS), "line length past store depth")
  `CLA_ASSERT(a_vis_le_len, vis_r <= len_r, "visible length exceeds stored length")
  `CLA_ASSERT(a_fetch_in_line, cmd.fetch |-> LW'(idx_r) < emit_len_r,
              "readout beyond closed line")

endmodule
`default_nettype wire

@@ sv/cla_ctrl.sv @@
// controller: takes characters and sequences the line readout
`default_nettype none
`include "console_line_assembler_assert.svh"
module cla_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_ready,
  input  cla_pkg::sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output cla_pkg::cmd_t cmd
);
  import cla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_SEND  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.emit) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CLA_ASSERT_ALL(a_reset_idle, !rst_n |=> state_r == S_IDLE, "not idle after reset")
  `CLA_ASSERT(a_fetch_send, cmd.fetch |=> out_valid, "fetched char not presented")
  `CLA_ASSERT(a_last_done, out_valid && out_ready && sts.last |=> in_ready,
              "input not reopened after last char")

endmodule
`default_nettype wire

@@ sv/console_line_assembler.sv @@
// top level of the console line assembler
//
//  channel   dir  handshake       payload
//  in_ch     in   valid / ready   ch[7:0]
//  out_ln    out  valid / ready   out_char[7:0], last
//  cfg       in   cfg_we          cfg_wdata (strip_escapes)
//
// a character that closes no line, or closes a blank one, is taken with no readout
// a closing character that emits n chars starts a readout of them: the line store
// has one registered read port, each char is fetched then presented
// input is held off while a line is read out; out_ln stalls hold the char
// synchronous active-low reset, no clearing pass over the line store
`default_nettype none
module console_line_assembler #(
  parameter int LINE_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  cla_in_if.sink    in_ch,
  cla_out_if.source out_ln,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import cla_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ln.ready),
    .sts       (sts),
    .in_ready  (in_ch.ready),
    .out_valid (out_ln.valid),
    .cmd       (cmd)
  );

  cla_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ch        (in_ch.ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_char  (out_ln.out_char),
    .out_last  (out_ln.last)
  );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// testbench for the console line assembler: directed and random lines, predicted and checked
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import cla_pkg::*;

  localparam int LINE_BYTES  = 64;
  localparam int MAX_CHARS   = LINE_BYTES - 2;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_char_t;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  cla_in_if  in_ch_if ();
  cla_out_if out_ln_if ();

  console_line_assembler #(.LINE_BYTES(LINE_BYTES)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch_if),
    .out_ln   (out_ln_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // line model state
  logic [7:0]  line_buf [0:MAX_CHARS-1];
  int unsigned line_len;
  int unsigned vis_len;
  bit          nul_in_line;
  bit          has_text;
  mode_t       parse_st;
  bit          strip_on;

  line_char_t  line_chars_due [$];
  int          mismatches;
  int unsigned chars_sent;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned hold_requests;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit is_escape_body(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI || c == CH_LBRK ||
           c == CH_RBRK || c == CH_LOW_M;
  endfunction

  function automatic void flush_line();
    line_char_t item;
    if (has_text) begin
      for (int i = 0; i < vis_len && i < MAX_CHARS; i++) begin
        item.ch   = line_buf[i];
        item.last = (i + 1 == vis_len);
        line_chars_due.push_back(item);
      end
    end
    line_len    = 0;
    vis_len     = 0;
    nul_in_line = 1'b0;
    has_text    = 1'b0;
  endfunction

  function automatic void assemble_char(logic [7:0] c);
    if (parse_st == MODE_ESCAPE) begin
      if (is_escape_body(c)) return;
      parse_st = MODE_NORMAL;
    end
    if (parse_st == MODE_OVERFLOW) begin
      if (c == CH_NL) parse_st = MODE_NORMAL;
      return;
    end
    if (c == CH_NL) begin
      flush_line();
      return;
    end
    if (strip_on && c == CH_ESC) begin
      parse_st = MODE_ESCAPE;
      return;
    end
    // no room left: the line closes early and this char is lost
    if (line_len > LINE_BYTES - 3) begin
      parse_st = MODE_OVERFLOW;
      flush_line();
      return;
    end
    if (line_len < MAX_CHARS) line_buf[line_len] = c;
    line_len++;
    if (!nul_in_line) begin
      if (c == CH_NUL) begin
        nul_in_line = 1'b1;
      end else begin
        vis_len++;
        if (c != CH_SPACE) has_text = 1'b1;
      end
    end
  endfunction

  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch_if.valid <= 1'b1;
    in_ch_if.ch    <= c;
    do @(posedge clk); while (!in_ch_if.ready);
    burst_left--;
    chars_sent++;
    assemble_char(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_repeat(input logic [7:0] c, input int n);
    for (int i = 0; i < n; i++) send_char(c);
  endtask

  // stop offering and let every pending line drain out
  task automatic wait_idle();
    in_ch_if.valid <= 1'b0;
    while (line_chars_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_strip(input bit v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    strip_on  = v;
  endtask

  // receiver: random ready patterns, plus long hold-offs on request
  initial begin
    int unsigned stretch;
    int unsigned hold_left;
    int unsigned hold_seen;
    rx_pattern_t pattern;
    out_ln_if.ready <= 1'b0;
    stretch   = 0;
    hold_left = 0;
    hold_seen = 0;
    pattern   = RX_ALWAYS;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ln_if.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          pattern = rx_pattern_t'($urandom_range(0, 3));
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        case (pattern)
          RX_ALWAYS: out_ln_if.ready <= 1'b1;
          RX_HALF:   out_ln_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ln_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ln_if.ready <= ~out_ln_if.ready;
        endcase
      end
    end
  end

  // compare each output transfer with the oldest predicted char
  always @(posedge clk) begin
    line_char_t due;
    if (rst_n && out_ln_if.valid && out_ln_if.ready) begin
      if (line_chars_due.size() == 0) begin
        $error("out_char: expected nothing, got %h (last %b)", out_ln_if.out_char,
               out_ln_if.last);
        mismatches++;
      end else begin
        due = line_chars_due.pop_front();
        if (out_ln_if.out_char !== due.ch) begin
          $error("out_char: expected %h, got %h", due.ch, out_ln_if.out_char);
          mismatches++;
        end
        if (out_ln_if.last !== due.last) begin
          $error("last: expected %b, got %b", due.last, out_ln_if.last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_plain_lines();
    send_text("A\n");
    send_text("\n");
    send_text("   \n");
    send_char(8'h01);
    send_char(8'hff);
    send_char(8'h80);
    send_text(" q \n");
  endtask

  task automatic test_nul_chars();
    send_char("a");
    send_char(CH_NUL);
    send_text("b\n");
    send_char(CH_NUL);
    send_text("x\n");
    send_char(CH_SPACE);
    send_char(CH_NUL);
    send_text("z\n");
  endtask

  task automatic test_escape_strip();
    send_char(CH_ESC);
    send_text("[31mH\n");
    send_char(CH_ESC);
    send_char(CH_ESC);
    send_text("];09k\n");
    send_text("p");
    send_char(CH_ESC);
    send_char(CH_NUL);
    send_text("r\n");
  endtask

  task automatic test_strip_off_mid_sequence();
    send_char(CH_ESC);
    send_char(CH_LBRK);
    set_strip(1'b0);
    // sequence already open still swallows the digit
    send_text("3A");
    send_char(CH_ESC);
    send_text("[q\n");
    set_strip(1'b1);
  endtask

  task automatic test_long_lines();
    send_repeat("x", MAX_CHARS);
    send_char(CH_NL);
    send_repeat("y", MAX_CHARS);
    // closes the line early, then everything up to the newline is skipped
    send_text("zq\n");
    send_text("k\n");
    send_repeat(CH_SPACE, MAX_CHARS);
    send_text("w\n");
  endtask

  task automatic test_receiver_hold();
    wait_idle();
    gap_max = 0;
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < 5; n++) begin
      for (int i = 0; i < 15; i++) send_char(8'($urandom_range(8'h21, 8'h7e)));
      send_char(CH_NL);
    end
    gap_max = 6;
    wait_idle();
  endtask

  function automatic logic [7:0] escape_body_char();
    int unsigned r;
    r = $urandom_range(0, 13);
    case (r)
      10:      return CH_SEMI;
      11:      return CH_LBRK;
      12:      return CH_RBRK;
      13:      return CH_LOW_M;
      default: return CH_ZERO + 8'(r);
    endcase
  endfunction

  function automatic logic [7:0] any_byte_but_newline();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
    return c;
  endfunction

  task automatic send_random_line();
    int unsigned kind;
    int unsigned len;
    int unsigned r;
    kind    = $urandom_range(0, 99);
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (kind < 8) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)));
    end else if (kind < 14) begin
      len = $urandom_range(55, 70);
      for (int i = 0; i < len; i++) send_char(8'($urandom_range(8'h21, 8'h7e)));
      if ($urandom_range(0, 9) < 7) send_char(CH_NL);
    end else if (kind < 20) begin
      send_repeat(CH_SPACE, int'($urandom_range(0, 5)));
      send_char(CH_NL);
    end else begin
      len = $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_char(8'($urandom_range(8'h21, 8'h7e)));
        end else if (r < 75) begin
          send_char(CH_SPACE);
        end else if (r < 80) begin
          send_char(CH_NUL);
        end else if (r < 88) begin
          send_char(CH_ESC);
          repeat ($urandom_range(0, 4)) send_char(escape_body_char());
        end else if (r < 95) begin
          send_char(any_byte_but_newline());
        end else begin
          send_char(CH_ESC);
        end
      end
      send_char(CH_NL);
    end
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned stop_at;
    stop_at = chars_sent + n;
    while (chars_sent < stop_at) send_random_line();
  endtask

  task automatic test_random_traffic();
    random_phase(40);
    set_strip(1'b0);
    random_phase(30);
    set_strip(1'b1);
    random_phase(30);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch_if.valid <= 1'b0;
    in_ch_if.ch    <= 8'h00;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    cycle_count    = 0;
    mismatches     = 0;
    chars_sent     = 0;
    burst_left     = 0;
    gap_max        = 4;
    hold_requests  = 0;
    strip_on       = 1'b1;
    parse_st       = MODE_NORMAL;
    line_len       = 0;
    vis_len        = 0;
    nul_in_line    = 1'b0;
    has_text       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_strip(1'b1);
    test_plain_lines();
    test_nul_chars();
    test_escape_strip();
    test_strip_off_mid_sequence();
    test_long_lines();
    test_receiver_hold();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && line_chars_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
